// File: hdl/escape_time_point_step_top_defines.svh
// assertion macros shared by the escape-time step block
`ifndef ESCAPE_TIME_POINT_STEP_TOP_DEFINES_SVH
`define ESCAPE_TIME_POINT_STEP_TOP_DEFINES_SVH

`ifndef SYNTHESIS

// same-cycle implication, checked at every rising edge outside reset
`define ETPS_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("etps assertion failed");

// next-cycle implication
`define ETPS_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("etps assertion failed");

`else

`define ETPS_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define ETPS_ASSERT_NXT(label, clk, rst_n, ante, cons)

`endif

`endif

// File: hdl/etps_pkg.sv
// types, constants and fixed-point helpers for the escape-time step block
package etps_pkg;

    localparam int VALUE_WIDTH   = 32;
    localparam int FRACTION_BITS = 27;
    localparam int COUNT_WIDTH   = 16;
    localparam int PROD_WIDTH    = 2 * VALUE_WIDTH;
    localparam int SUM_WIDTH     = 2 * VALUE_WIDTH + 2;
    localparam int MAG_WIDTH     = VALUE_WIDTH + 1;
    localparam int MSUM_WIDTH    = VALUE_WIDTH + 2;
    localparam int FORMULA_WIDTH = 3;

    typedef logic signed [VALUE_WIDTH-1:0] value_t;
    typedef logic [COUNT_WIDTH-1:0]        count_t;
    typedef logic signed [PROD_WIDTH-1:0]  prod_t;
    typedef logic signed [SUM_WIDTH-1:0]   sum_t;
    typedef logic [MAG_WIDTH-1:0]          mag_t;
    typedef logic [MSUM_WIDTH-1:0]         msum_t;

    localparam msum_t  ESCAPE_LIMIT = msum_t'(2) << FRACTION_BITS;
    localparam count_t COUNT_MAX    = '1;

    typedef enum logic [FORMULA_WIDTH-1:0] {
        FORMULA_MANDELBROT  = 3'd0,
        FORMULA_SQUARE      = 3'd1,
        FORMULA_NOT_CIRCLE  = 3'd2,
        FORMULA_COLLAPSE_Y2 = 3'd3,
        FORMULA_IGNORE_Y2   = 3'd4
    } formula_t;

    typedef struct packed {
        value_t coord_x;
        value_t coord_y;
        value_t z_real;
        value_t z_imag;
        count_t count;
        count_t escape;
    } point_t;

    typedef struct packed {
        point_t point;
        prod_t  xx;
        prod_t  yy;
        prod_t  xy;
        logic   escape_now;
    } product_t;

    typedef struct packed {
        value_t z_real;
        value_t z_imag;
        count_t count;
        count_t escape;
    } result_t;

    function automatic mag_t magnitude(value_t v);
        mag_t w;
        w = mag_t'(v);
        if (v[VALUE_WIDTH-1])
            w = mag_t'(0) - w;
        return w;
    endfunction

    function automatic sum_t widen_value(value_t v);
        return sum_t'(v);
    endfunction

    function automatic sum_t widen_prod(prod_t p);
        return sum_t'(p);
    endfunction

    // floor back to FRACTION_BITS fraction bits, then clamp to the value range
    function automatic value_t finish(sum_t s);
        sum_t sh;
        logic all_zero;
        logic all_one;
        sh       = s >>> FRACTION_BITS;
        all_zero = ~|sh[SUM_WIDTH-1:VALUE_WIDTH-1];
        all_one  = &sh[SUM_WIDTH-1:VALUE_WIDTH-1];
        if (all_zero || all_one)
            return sh[VALUE_WIDTH-1:0];
        else if (sh[SUM_WIDTH-1])
            return {1'b1, {(VALUE_WIDTH-1){1'b0}}};
        else
            return {1'b0, {(VALUE_WIDTH-1){1'b1}}};
    endfunction

endpackage

// File: hdl/escape_time_point_step_top.sv
// top level of the escape-time step block: handshakes, stage registers, formula register
// One point record (c, z, count, escape mark) goes in per transaction and one advanced
// record comes out. The block is a three-register pipeline: an input register, a
// product register after the three 32x32 multipliers (zr*zr, zi*zi, zr*zi) together
// with the |zr|+|zi| > 2 test, and a result register after the formula sums, the
// floor rounding and the saturation. A new transaction is taken every cycle unless the
// output stalls, and each record passes the input, product and result registers in turn
// before it is offered at the output. Back-pressure on the output travels back through
// the stage valids, so with all three stages full and out_ready low, in_ready drops. The
// formula register is written through the cfg channel, which is always ready; it must
// only be changed while no transaction is in flight. Codes 5 to 7 behave as Mandelbrot.
`include "escape_time_point_step_top_defines.svh"

module escape_time_point_step_top import etps_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,

    // configuration write channel
    input  logic                     cfg_valid,
    output logic                     cfg_ready,
    input  logic [FORMULA_WIDTH-1:0] cfg_data,

    // input point record
    input  logic                     in_valid,
    output logic                     in_ready,
    input  logic signed [VALUE_WIDTH-1:0] coord_x,
    input  logic signed [VALUE_WIDTH-1:0] coord_y,
    input  logic signed [VALUE_WIDTH-1:0] z_real,
    input  logic signed [VALUE_WIDTH-1:0] z_imag,
    input  logic [COUNT_WIDTH-1:0]   count_in,
    input  logic [COUNT_WIDTH-1:0]   escape_in,

    // advanced point record
    output logic                     out_valid,
    input  logic                     out_ready,
    output logic signed [VALUE_WIDTH-1:0] z_real_next,
    output logic signed [VALUE_WIDTH-1:0] z_imag_next,
    output logic [COUNT_WIDTH-1:0]   count_out,
    output logic [COUNT_WIDTH-1:0]   escape_out
);

    // formula selection, reset to mandelbrot
    logic [FORMULA_WIDTH-1:0] formula_reg;

    // stage valids and payloads
    logic     s0_valid_reg;
    logic     s1_valid_reg;
    logic     s2_valid_reg;
    point_t   s0_reg;
    product_t s1_reg;
    result_t  s2_reg;

    // stage enables: a stage may load when it is empty or its contents move on
    logic     s1_en;
    logic     s2_en;

    point_t   in_point;
    product_t s1_next;
    result_t  s2_next;

    assign cfg_ready = 1'b1;

    assign s2_en    = !s2_valid_reg || out_ready;
    assign s1_en    = !s1_valid_reg || s2_en;
    assign in_ready = !s0_valid_reg || s1_en;

    assign in_point.coord_x = coord_x;
    assign in_point.coord_y = coord_y;
    assign in_point.z_real  = z_real;
    assign in_point.z_imag  = z_imag;
    assign in_point.count   = count_in;
    assign in_point.escape  = escape_in;

    // multipliers and escape test
    etps_product u_product
    (
        .point   (s0_reg),
        .product (s1_next)
    );

    // formula sums, rounding, saturation
    etps_combine u_combine
    (
        .formula (formula_reg),
        .product (s1_reg),
        .result  (s2_next)
    );

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            formula_reg  <= FORMULA_MANDELBROT;
            s0_valid_reg <= 1'b0;
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
                formula_reg <= cfg_data;
            if (in_ready)
                s0_valid_reg <= in_valid;
            if (s1_en)
                s1_valid_reg <= s0_valid_reg;
            if (s2_en)
                s2_valid_reg <= s1_valid_reg;
        end
    end

    // payload registers, loaded only when a record moves in
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
            s0_reg <= in_point;
        if (s1_en && s0_valid_reg)
            s1_reg <= s1_next;
        if (s2_en && s1_valid_reg)
            s2_reg <= s2_next;
    end

    assign out_valid   = s2_valid_reg;
    assign z_real_next = s2_reg.z_real;
    assign z_imag_next = s2_reg.z_imag;
    assign count_out   = s2_reg.count;
    assign escape_out  = s2_reg.escape;

    // input only blocks when every stage holds a record
    `ETPS_ASSERT_IMP(a_blocked_only_when_full, clk, rst_n, !in_ready,
                     s0_valid_reg && s1_valid_reg && s2_valid_reg)

    // a record held in the product stage is never dropped while the output stalls
    `ETPS_ASSERT_NXT(a_product_held, clk, rst_n, s1_valid_reg && !s2_en, s1_valid_reg)

    // a record leaving the input stage always lands in the product stage
    `ETPS_ASSERT_NXT(a_input_moves, clk, rst_n, s0_valid_reg && s1_en, s1_valid_reg)

    // an already escaped record keeps its mark through the final stage
    `ETPS_ASSERT_NXT(a_escaped_passes, clk, rst_n,
                     s2_en && s1_valid_reg && (s1_reg.point.escape != '0),
                     out_valid && (escape_out == $past(s1_reg.point.escape)))

endmodule

// File: hdl/etps_product.sv
// first stage: the three products of z and the escape test
module etps_product import etps_pkg::*;
(
    input  point_t   point,
    output product_t product
);

    mag_t  mag_real;
    mag_t  mag_imag;
    msum_t mag_sum;

    assign mag_real = magnitude(point.z_real);
    assign mag_imag = magnitude(point.z_imag);
    assign mag_sum  = msum_t'(mag_real) + msum_t'(mag_imag);

    assign product.point      = point;
    assign product.xx         = $signed(point.z_real) * $signed(point.z_real);
    assign product.yy         = $signed(point.z_imag) * $signed(point.z_imag);
    assign product.xy         = $signed(point.z_real) * $signed(point.z_imag);
    // exactly 2 stays inside
    assign product.escape_now = mag_sum > ESCAPE_LIMIT;

endmodule

// File: hdl/etps_combine.sv
// second stage: formula sums, rounding, saturation and count update
module etps_combine import etps_pkg::*;
(
    input  logic [FORMULA_WIDTH-1:0] formula,
    input  product_t                 product,
    output result_t                  result
);

    point_t p;
    sum_t   lift_x;
    sum_t   lift_y;
    sum_t   xy2;
    value_t imag_first;

    assign p      = product.point;
    assign lift_x = widen_value(p.coord_x) <<< FRACTION_BITS;
    assign lift_y = widen_value(p.coord_y) <<< FRACTION_BITS;
    assign xy2    = widen_prod(product.xy) <<< 1;

    // not-a-circle: the imaginary part is formed first and feeds the real part
    assign imag_first = finish(widen_prod(product.yy)
                               + (widen_value(p.z_real) <<< (FRACTION_BITS - 1)));

    always_comb
    begin
        result.z_real = p.z_real;
        result.z_imag = p.z_imag;
        result.count  = p.count;
        result.escape = p.escape;
        if (p.escape == '0)
        begin
            if (product.escape_now)
            begin
                result.escape = p.count;
            end
            else
            begin
                case (formula)
                    FORMULA_SQUARE:
                    begin
                        result.z_imag = (p.z_imag == '0) ? p.coord_y
                                                         : finish(widen_prod(product.yy));
                        result.z_real = (p.z_real == '0) ? p.coord_x
                                                         : finish(widen_prod(product.xx));
                    end
                    FORMULA_NOT_CIRCLE:
                    begin
                        if (p.count == '0)
                        begin
                            result.z_real = p.coord_x;
                            result.z_imag = p.coord_y;
                        end
                        else
                        begin
                            result.z_imag = imag_first;
                            result.z_real = finish(widen_prod(product.xx)
                                + (widen_value(imag_first) <<< (FRACTION_BITS - 1)));
                        end
                    end
                    FORMULA_COLLAPSE_Y2:
                    begin
                        result.z_real = finish(widen_prod(product.xx) + lift_x);
                        result.z_imag = finish(xy2 + widen_prod(product.yy) + lift_y);
                    end
                    FORMULA_IGNORE_Y2:
                    begin
                        result.z_real = finish(widen_prod(product.xx) + lift_x);
                        result.z_imag = finish(xy2 + lift_y);
                    end
                    default:
                    begin
                        result.z_real = finish(widen_prod(product.xx)
                                               - widen_prod(product.yy) + lift_x);
                        result.z_imag = finish(xy2 + lift_y);
                    end
                endcase
                result.count = (p.count == COUNT_MAX) ? p.count : p.count + count_t'(1);
            end
        end
    end

endmodule

// File: dv/escape_time_point_step_checker.sv
// checker for the escape-time step block: predicts each advanced point record and compares
module escape_time_point_step_checker import etps_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,

    input  logic                     cfg_valid,
    input  logic                     cfg_ready,
    input  logic [FORMULA_WIDTH-1:0] cfg_data,

    input  logic                     in_valid,
    input  logic                     in_ready,
    input  value_t                   coord_x,
    input  value_t                   coord_y,
    input  value_t                   z_real,
    input  value_t                   z_imag,
    input  count_t                   count_in,
    input  count_t                   escape_in,

    input  logic                     out_valid,
    input  logic                     out_ready,
    input  value_t                   z_real_next,
    input  value_t                   z_imag_next,
    input  count_t                   count_out,
    input  count_t                   escape_out,

    output int                       fail_count,
    output int                       pending,
    output int                       checked,
    output int                       escaped
);
    timeunit 1ns;
    timeprecision 1ps;

    // wide enough for every exact sum at twice the fraction bits
    typedef logic signed [71:0] wide_t;

    localparam wide_t Q_MAX = (wide_t'(1) <<< (VALUE_WIDTH - 1)) - 1;
    localparam wide_t Q_MIN = -(wide_t'(1) <<< (VALUE_WIDTH - 1));
    localparam wide_t TWO_Q = wide_t'(2) <<< FRACTION_BITS;

    logic [FORMULA_WIDTH-1:0] formula_sel;
    result_t                  advanced_points[$];

    // floor back to the value's fraction bits, then clamp
    function automatic value_t floor_clamp(wide_t acc);
        wide_t q;
        q = acc >>> FRACTION_BITS;
        if (q > Q_MAX)
            return value_t'(Q_MAX);
        if (q < Q_MIN)
            return value_t'(Q_MIN);
        return value_t'(q);
    endfunction

    function automatic result_t step_point(logic [FORMULA_WIDTH-1:0] sel,
                                           value_t cx, value_t cy,
                                           value_t zr, value_t zi,
                                           count_t cnt, count_t esc);
        wide_t   wr;
        wide_t   wi;
        wide_t   mr;
        wide_t   mi;
        wide_t   xx;
        wide_t   yy;
        wide_t   xy2;
        wide_t   lcx;
        wide_t   lcy;
        value_t  ni;
        result_t r;
        r.z_real = zr;
        r.z_imag = zi;
        r.count  = cnt;
        r.escape = esc;
        if (esc != '0)
            return r;
        wr = wide_t'(zr);
        wi = wide_t'(zi);
        mr = (wr < 0) ? -wr : wr;
        mi = (wi < 0) ? -wi : wi;
        if (mr + mi > TWO_Q)
        begin
            r.escape = cnt;
            return r;
        end
        xx  = wr * wr;
        yy  = wi * wi;
        xy2 = (wr * wi) <<< 1;
        lcx = wide_t'(cx) <<< FRACTION_BITS;
        lcy = wide_t'(cy) <<< FRACTION_BITS;
        case (sel)
            FORMULA_SQUARE:
            begin
                r.z_imag = (zi == '0) ? cy : floor_clamp(yy);
                r.z_real = (zr == '0) ? cx : floor_clamp(xx);
            end
            FORMULA_NOT_CIRCLE:
            begin
                if (cnt == '0)
                begin
                    r.z_real = cx;
                    r.z_imag = cy;
                end
                else
                begin
                    // the new, already clamped imaginary part feeds the real part
                    ni       = floor_clamp(yy + (wr <<< (FRACTION_BITS - 1)));
                    r.z_imag = ni;
                    r.z_real = floor_clamp(xx + (wide_t'(ni) <<< (FRACTION_BITS - 1)));
                end
            end
            FORMULA_COLLAPSE_Y2:
            begin
                r.z_real = floor_clamp(xx + lcx);
                r.z_imag = floor_clamp(xy2 + yy + lcy);
            end
            FORMULA_IGNORE_Y2:
            begin
                r.z_real = floor_clamp(xx + lcx);
                r.z_imag = floor_clamp(xy2 + lcy);
            end
            default:
            begin
                r.z_real = floor_clamp(xx - yy + lcx);
                r.z_imag = floor_clamp(xy2 + lcy);
            end
        endcase
        if (cnt != COUNT_MAX)
            r.count = cnt + 1'b1;
        return r;
    endfunction

    task automatic check_field(input string name, input logic signed [63:0] want,
                               input logic signed [63:0] got);
        if (got !== want)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            fail_count++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        result_t want;
        if (!rst_n)
        begin
            formula_sel = FORMULA_MANDELBROT;
            advanced_points.delete();
            pending = 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
                formula_sel = cfg_data;
            if (in_valid && in_ready)
                advanced_points.push_back(step_point(formula_sel, coord_x, coord_y,
                                                     z_real, z_imag, count_in, escape_in));
            if (out_valid && out_ready)
            begin
                if (advanced_points.size() == 0)
                begin
                    $error("advanced point record with no transaction outstanding");
                    fail_count++;
                end
                else
                begin
                    want = advanced_points.pop_front();
                    checked++;
                    if (want.escape != '0)
                        escaped++;
                    check_field("z_real_next", $signed(want.z_real), z_real_next);
                    check_field("z_imag_next", $signed(want.z_imag), z_imag_next);
                    check_field("count_out", want.count, count_out);
                    check_field("escape_out", want.escape, escape_out);
                end
            end
            pending = advanced_points.size();
        end
    end

endmodule

// File: dv/tb_escape_time_point_step_top.sv
// testbench top for the escape-time step block: stimulus, idling and verdict
module tb_escape_time_point_step_top import etps_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    // fixed-point landmarks in the block's Q format
    localparam value_t      Q_ONE   = value_t'(1 << FRACTION_BITS);
    localparam value_t      Q_HALF  = value_t'(1 << (FRACTION_BITS - 1));
    localparam value_t      Q_TWO   = value_t'(2 << FRACTION_BITS);
    localparam value_t      Q_MAX   = {1'b0, {(VALUE_WIDTH-1){1'b1}}};
    localparam value_t      Q_MIN   = {1'b1, {(VALUE_WIDTH-1){1'b0}}};
    localparam int unsigned TWO_RAW = 2 << FRACTION_BITS;
    // 2.5, a little beyond the interesting part of the plane
    localparam int unsigned C_SPAN  = 5 << (FRACTION_BITS - 1);

    // a code with no formula of its own; the block treats it as mandelbrot
    localparam logic [FORMULA_WIDTH-1:0] FORMULA_SPARE_CODE = 3'd7;

    localparam int RANDOM_PER_SETTING = 57;

    logic                     clk;
    logic                     rst_n;
    logic                     cfg_valid;
    logic                     cfg_ready;
    logic [FORMULA_WIDTH-1:0] cfg_data;
    logic                     in_valid;
    logic                     in_ready;
    value_t                   coord_x;
    value_t                   coord_y;
    value_t                   z_real;
    value_t                   z_imag;
    count_t                   count_in;
    count_t                   escape_in;
    logic                     out_valid;
    logic                     out_ready;
    value_t                   z_real_next;
    value_t                   z_imag_next;
    count_t                   count_out;
    count_t                   escape_out;

    int fail_count;
    int pending_points;
    int results_checked;
    int escapes_seen;

    int points_sent;
    int formula_writes;
    int ready_hold;
    bit idle_on;

    // 20 ns clock
    always
    begin
        clk = 1'b1;
        #10;
        clk = 1'b0;
        #10;
    end

    escape_time_point_step_top uut
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_data    (cfg_data),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .coord_x     (coord_x),
        .coord_y     (coord_y),
        .z_real      (z_real),
        .z_imag      (z_imag),
        .count_in    (count_in),
        .escape_in   (escape_in),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .z_real_next (z_real_next),
        .z_imag_next (z_imag_next),
        .count_out   (count_out),
        .escape_out  (escape_out)
    );

    // watches all three channels, predicts and compares
    escape_time_point_step_checker point_checker
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_data    (cfg_data),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .coord_x     (coord_x),
        .coord_y     (coord_y),
        .z_real      (z_real),
        .z_imag      (z_imag),
        .count_in    (count_in),
        .escape_in   (escape_in),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .z_real_next (z_real_next),
        .z_imag_next (z_imag_next),
        .count_out   (count_out),
        .escape_out  (escape_out),
        .fail_count  (fail_count),
        .pending     (pending_points),
        .checked     (results_checked),
        .escaped     (escapes_seen)
    );

    // output back-pressure: stalls of random length while idling is on,
    // exactly one nonblocking write of out_ready per falling edge
    always @(negedge clk)
    begin
        if (ready_hold > 0)
        begin
            ready_hold--;
            out_ready <= 1'b0;
        end
        else if (idle_on && $urandom_range(0, 5) == 0)
        begin
            ready_hold = $urandom_range(1, 5) - 1;
            out_ready <= 1'b0;
        end
        else
        begin
            out_ready <= 1'b1;
        end
    end

    // symmetric random value within +/- span (raw fixed-point units)
    function automatic value_t signed_within(int unsigned span);
        value_t v;
        v = value_t'($urandom_range(0, span));
        if ($urandom_range(0, 1) == 1)
            v = -v;
        return v;
    endfunction

    // one input transaction; an optional idle burst goes in front of it, and valid
    // stays high with the payload held until the block takes it
    task automatic send_point(input value_t cx, input value_t cy,
                              input value_t zr, input value_t zi,
                              input count_t cnt, input count_t esc);
        if (idle_on && $urandom_range(0, 3) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(negedge clk);
        end
        in_valid  <= 1'b1;
        coord_x   <= cx;
        coord_y   <= cy;
        z_real    <= zr;
        z_imag    <= zi;
        count_in  <= cnt;
        escape_in <= esc;
        do
            @(posedge clk);
        while (!in_ready);
        @(negedge clk);
        points_sent++;
    endtask

    // random point record; most are live points whose z lies inside the escape
    // diamond so that the formula is really exercised, the rest are passed-through,
    // escaping or fully random records
    task automatic send_random_point();
        int unsigned kind;
        int unsigned left;
        value_t      cx;
        value_t      cy;
        value_t      zr;
        value_t      zi;
        count_t      cnt;
        count_t      esc;
        kind = $urandom_range(0, 99);
        cx   = $urandom;
        cy   = $urandom;
        zr   = $urandom;
        zi   = $urandom;
        cnt  = $urandom;
        esc  = $urandom;
        if ($urandom_range(0, 9) < 7)
            cnt = $urandom_range(0, 300);
        case ($urandom_range(0, 19))
            0: cnt = '0;
            1: cnt = COUNT_MAX;
            default: ;
        endcase
        if (kind < 70)
        begin
            // live point: |zr| + |zi| <= 2, now and then exactly on the boundary
            esc  = '0;
            zr   = signed_within(TWO_RAW);
            left = TWO_RAW - ((zr < 0) ? int'(-zr) : int'(zr));
            if ($urandom_range(0, 7) == 0)
                zi = ($urandom_range(0, 1) == 1) ? value_t'(left) : -value_t'(left);
            else
                zi = signed_within(left);
            if ($urandom_range(0, 4) != 0)
            begin
                cx = signed_within(C_SPAN);
                cy = signed_within(C_SPAN);
            end
        end
        else if (kind < 80)
        begin
            // already escaped, must pass through untouched
            if (esc == '0)
                esc = 16'd1;
        end
        else if (kind < 90)
        begin
            // z from anywhere, so mostly escaping on this step
            esc = '0;
        end
        send_point(cx, cy, zr, zi, cnt, esc);
    endtask

    // formula change only with the pipeline drained
    task automatic write_formula(input logic [FORMULA_WIDTH-1:0] code);
        in_valid <= 1'b0;
        wait (pending_points == 0);
        // let the three stages settle before touching the register
        repeat (4) @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= code;
        do
            @(posedge clk);
        while (!cfg_ready);
        @(negedge clk);
        cfg_valid <= 1'b0;
        formula_writes++;
    endtask

    initial
    begin
        // every input known from time zero, reset held low before release
        rst_n       = 1'b0;
        cfg_valid   = 1'b0;
        cfg_data    = FORMULA_MANDELBROT;
        in_valid    = 1'b0;
        coord_x     = '0;
        coord_y     = '0;
        z_real      = '0;
        z_imag      = '0;
        count_in    = '0;
        escape_in   = '0;
        out_ready   = 1'b0;
        ready_hold  = 0;
        idle_on     = 1'b1;
        points_sent = 0;
        formula_writes = 0;
        repeat (10) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // mandelbrot straight out of reset
        send_point('0, '0, '0, '0, '0, '0);                       // origin, first step
        send_point(Q_MAX, Q_MIN, '0, '0, 16'd5, '0);             // c at its extremes
        send_point(Q_MIN, Q_MAX, Q_MAX, Q_MIN, COUNT_MAX, COUNT_MAX); // escaped, all extremes
        send_point(Q_ONE, -Q_ONE, Q_MAX, Q_MAX, 16'd12, 16'd1);  // escaped pass-through
        send_point(Q_ONE, Q_ONE, Q_TWO, '0, 16'd3, '0);          // magnitude sum exactly two
        send_point('0, '0, Q_ONE, -Q_ONE, 16'd4, '0);            // two again, split across parts
        send_point('0, '0, Q_TWO, value_t'(1), 16'd7, '0);       // one lsb over, escapes now
        send_point(Q_ONE, Q_ONE, Q_MIN, Q_MIN, '0, '0);          // escapes with count zero
        send_point('0, '0, Q_MIN, '0, 16'd3, '0);                // most negative real part
        send_point(-Q_HALF, Q_HALF, Q_HALF, -Q_HALF, COUNT_MAX, '0); // count saturated
        send_point(Q_MAX, Q_MAX, Q_TWO, '0, 16'd2, '0);          // clamps positive
        send_point(Q_MIN, Q_MIN, '0, Q_TWO, 16'd2, '0);          // clamps negative
        send_point('0, '0, value_t'(-1), value_t'(1), 16'd1, '0); // floor of a tiny negative
        repeat (RANDOM_PER_SETTING) send_random_point();

        write_formula(FORMULA_SQUARE);
        send_point(Q_HALF, -Q_HALF, '0, '0, 16'd1, '0);          // zero parts take c
        send_point(Q_ONE, Q_ONE, Q_TWO, '0, 16'd6, '0);          // zero imaginary part only
        send_point(Q_ONE, Q_ONE, -Q_HALF, Q_ONE + Q_HALF, 16'd6, '0);
        repeat (RANDOM_PER_SETTING) send_random_point();

        write_formula(FORMULA_NOT_CIRCLE);
        send_point(Q_MAX, Q_MIN, Q_ONE, Q_ONE, '0, '0);          // count zero loads c
        send_point('0, '0, -Q_ONE, Q_ONE, 16'd1, '0);
        send_point('0, '0, Q_TWO, '0, 16'd9, '0);
        repeat (RANDOM_PER_SETTING) send_random_point();

        write_formula(FORMULA_COLLAPSE_Y2);
        send_point(Q_MAX, Q_MAX, Q_ONE, Q_ONE, 16'd6, '0);       // clamps positive
        send_point(-Q_HALF, Q_HALF, Q_HALF, -Q_ONE, 16'd6, '0);
        repeat (RANDOM_PER_SETTING) send_random_point();

        write_formula(FORMULA_IGNORE_Y2);
        send_point(Q_MIN, Q_MIN, -Q_ONE, Q_ONE, 16'd8, '0);      // clamps negative
        send_point(Q_HALF, Q_HALF, Q_HALF, Q_HALF, COUNT_MAX, '0);
        repeat (RANDOM_PER_SETTING) send_random_point();

        write_formula(FORMULA_SPARE_CODE);
        send_point(Q_ONE, -Q_HALF, Q_HALF, Q_ONE, 16'd2, '0);
        repeat (RANDOM_PER_SETTING) send_random_point();

        // last stretch back on mandelbrot at full rate, no idling on either side
        write_formula(FORMULA_MANDELBROT);
        idle_on = 1'b0;
        repeat (RANDOM_PER_SETTING) send_random_point();
        in_valid <= 1'b0;

        // drain, then wait for anything spurious to show up
        wait (pending_points == 0);
        repeat (8) @(negedge clk);

        $display("stimulus: %0d point records across %0d formula writes, spare code included",
                 points_sent, formula_writes);
        $display("checked %0d advanced records, %0d of them carrying an escape mark",
                 results_checked, escapes_seen);
        if (fail_count == 0 && pending_points == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

    // watchdog, far beyond the slowest legal run
    initial
    begin
        #4_000_000;
        $display("timeout: %0d point records still outstanding", pending_points);
        $display("Test completed with failures");
        $finish;
    end

endmodule
